FILE: rtl/lcp_pkg.sv
`default_nettype none
package lcp_pkg;

  // LED count is fixed by the pattern tables
  localparam int LED_COUNT = 8;

  // key codes
  localparam logic [2:0] KEY_NONE = 3'd0;
  localparam logic [2:0] KEY_MODE = 3'd1;
  localparam logic [2:0] KEY_RUN  = 3'd2;
  localparam logic [2:0] KEY_DOWN = 3'd3;
  localparam logic [2:0] KEY_UP   = 3'd4;

  // operating modes
  localparam logic [1:0] MODE_SHOW     = 2'd0;
  localparam logic [1:0] MODE_PATTERN  = 2'd1;
  localparam logic [1:0] MODE_INTERVAL = 2'd2;

  // pattern codes
  localparam logic [2:0] PAT_NONE = 3'd0;
  localparam logic [2:0] PAT_LR   = 3'd1;
  localparam logic [2:0] PAT_RL   = 3'd2;
  localparam logic [2:0] PAT_IN   = 3'd3;
  localparam logic [2:0] PAT_OUT  = 3'd4;

  // frame interval limits, in ticks
  localparam logic [10:0] INTERVAL_MIN  = 11'd400;
  localparam logic [10:0] INTERVAL_MAX  = 11'd1200;
  localparam logic [10:0] INTERVAL_STEP = 11'd100;

  // sample thresholds: volts = floor(v / 51)
  localparam logic [7:0] ADC_2V = 8'd102;
  localparam logic [7:0] ADC_3V = 8'd153;
  localparam logic [7:0] ADC_4V = 8'd204;

  // duty per band
  localparam logic [6:0] DUTY_L1 = 7'd90;
  localparam logic [6:0] DUTY_L2 = 7'd50;
  localparam logic [6:0] DUTY_L3 = 7'd10;
  localparam logic [6:0] DUTY_L4 = 7'd0;

  localparam logic [7:0] LEDS_OFF = 8'hff;

  typedef struct packed {
    logic [2:0] key;
    logic       adc_valid;
    logic [7:0] adc_value;
  } item_t;

  typedef struct packed {
    logic [7:0]  led_drive;
    logic [1:0]  mode_now;
    logic [2:0]  pattern_now;
    logic [10:0] interval_now;
    logic [2:0]  level_now;
    logic        running_now;
  } result_t;

  // frame table lookup; unknown pattern keeps the current byte
  function automatic logic [7:0] pattern_frame(input logic [2:0] p, input logic [2:0] idx,
                                               input logic [7:0] keep);
    logic [7:0] b;
    b = keep;
    case (p)
      PAT_LR: begin
        case (idx)
          3'd0: b = 8'h7f;
          3'd1: b = 8'hbf;
          3'd2: b = 8'hdf;
          3'd3: b = 8'hef;
          3'd4: b = 8'hf7;
          3'd5: b = 8'hfb;
          3'd6: b = 8'hfd;
          default: b = 8'hfe;
        endcase
      end
      PAT_RL: begin
        case (idx)
          3'd0: b = 8'hfe;
          3'd1: b = 8'hfd;
          3'd2: b = 8'hfb;
          3'd3: b = 8'hf7;
          3'd4: b = 8'hef;
          3'd5: b = 8'hdf;
          3'd6: b = 8'hbf;
          default: b = 8'h7f;
        endcase
      end
      PAT_IN: begin
        case (idx[1:0])
          2'd0: b = 8'h7e;
          2'd1: b = 8'hbd;
          2'd2: b = 8'hdb;
          default: b = 8'he7;
        endcase
      end
      PAT_OUT: begin
        case (idx[1:0])
          2'd0: b = 8'he7;
          2'd1: b = 8'hdb;
          2'd2: b = 8'hbd;
          default: b = 8'h7e;
        endcase
      end
      default: b = keep;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/lcp_core.sv
`default_nettype none
module lcp_core import lcp_pkg::*; #(
  parameter int PWM_PERIOD = 100
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    step,
  input  wire item_t   item,
  output result_t      result
);

  localparam int PHASE_W = (PWM_PERIOD > 2) ? $clog2(PWM_PERIOD) : 1;
  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(PWM_PERIOD - 1);

  logic [1:0]         mode_reg, mode_reg_next;
  logic [2:0]         current_pattern, current_pattern_next;
  logic [10:0]        frame_interval, frame_interval_next;
  logic               run_flag, run_flag_next;
  logic [6:0]         duty, duty_next;
  logic [2:0]         level, level_next;
  logic [PHASE_W-1:0] pwm_phase, pwm_phase_next;
  logic [10:0]        frame_ticks, frame_ticks_next;
  logic [2:0]         frame_index, frame_index_next;
  logic [7:0]         frame_byte, frame_byte_next;

  logic [3:0]  pat_len;
  logic [11:0] ticks_inc;
  logic [3:0]  idx_inc;
  logic [7:0]  drive;

  // one tick: key, then sample, then animation, then PWM
  always_comb begin
    mode_reg_next        = mode_reg;
    current_pattern_next = current_pattern;
    frame_interval_next  = frame_interval;
    run_flag_next        = run_flag;
    duty_next            = duty;
    level_next           = level;
    frame_ticks_next     = frame_ticks;
    frame_index_next     = frame_index;
    frame_byte_next      = frame_byte;

    // keys
    case (item.key)
      KEY_MODE: mode_reg_next = (mode_reg >= MODE_INTERVAL) ? MODE_SHOW : mode_reg + 2'd1;
      KEY_RUN:  run_flag_next = ~run_flag;
      KEY_DOWN: begin
        if (mode_reg == MODE_PATTERN) begin
          current_pattern_next = (current_pattern <= PAT_LR || current_pattern > PAT_OUT)
                                 ? PAT_OUT : current_pattern - 3'd1;
          frame_index_next = 3'd0;
          frame_ticks_next = 11'd0;
        end else if (mode_reg == MODE_INTERVAL) begin
          frame_interval_next = (frame_interval < INTERVAL_MIN + INTERVAL_STEP)
                                ? INTERVAL_MAX : frame_interval - INTERVAL_STEP;
        end
      end
      KEY_UP: begin
        if (mode_reg == MODE_PATTERN) begin
          current_pattern_next = (current_pattern >= PAT_OUT) ? PAT_LR : current_pattern + 3'd1;
          frame_index_next = 3'd0;
          frame_ticks_next = 11'd0;
        end else if (mode_reg == MODE_INTERVAL) begin
          frame_interval_next = (frame_interval > INTERVAL_MAX - INTERVAL_STEP)
                                ? INTERVAL_MIN : frame_interval + INTERVAL_STEP;
        end
      end
      default: ;
    endcase

    // light level band
    if (item.adc_valid) begin
      if (item.adc_value < ADC_2V) begin
        duty_next = DUTY_L1; level_next = 3'd1;
      end else if (item.adc_value < ADC_3V) begin
        duty_next = DUTY_L2; level_next = 3'd2;
      end else if (item.adc_value < ADC_4V) begin
        duty_next = DUTY_L3; level_next = 3'd3;
      end else begin
        duty_next = DUTY_L4; level_next = 3'd4;
      end
    end

    // animation
    pat_len   = (current_pattern_next == PAT_LR || current_pattern_next == PAT_RL)
                ? 4'(LED_COUNT) : 4'(LED_COUNT / 2);
    ticks_inc = 12'd0;
    idx_inc   = 4'd0;
    if (mode_reg_next == MODE_SHOW && run_flag_next &&
        current_pattern_next >= PAT_LR && current_pattern_next <= PAT_OUT) begin
      if ({1'b0, frame_index_next} >= pat_len)
        frame_index_next = 3'd0;
      if (frame_ticks_next == 11'd0)
        frame_byte_next = pattern_frame(current_pattern_next, frame_index_next, frame_byte);
      ticks_inc = {1'b0, frame_ticks_next} + 12'd1;
      if (ticks_inc >= {1'b0, frame_interval_next}) begin
        frame_ticks_next = 11'd0;
        idx_inc = {1'b0, frame_index_next} + 4'd1;
        frame_index_next = (idx_inc >= pat_len) ? 3'd0 : idx_inc[2:0];
      end else begin
        frame_ticks_next = ticks_inc[10:0];
      end
    end

    // PWM gating
    pwm_phase_next = (pwm_phase == PHASE_LAST) ? '0 : pwm_phase + 1'b1;
    drive = (8'(pwm_phase_next) < {1'b0, duty_next}) ? frame_byte_next : LEDS_OFF;
    if (!run_flag_next)
      drive = LEDS_OFF;

    result.led_drive    = drive;
    result.mode_now     = mode_reg_next;
    result.pattern_now  = current_pattern_next;
    result.interval_now = frame_interval_next;
    result.level_now    = level_next;
    result.running_now  = run_flag_next;
  end

  // state registers, updated on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg        <= MODE_SHOW;
      current_pattern <= PAT_NONE;
      frame_interval  <= INTERVAL_MIN;
      run_flag        <= 1'b1;
      duty            <= 7'd0;
      level           <= 3'd0;
      pwm_phase       <= '0;
      frame_ticks     <= 11'd0;
      frame_index     <= 3'd0;
      frame_byte      <= LEDS_OFF;
    end else if (step) begin
      mode_reg        <= mode_reg_next;
      current_pattern <= current_pattern_next;
      frame_interval  <= frame_interval_next;
      run_flag        <= run_flag_next;
      duty            <= duty_next;
      level           <= level_next;
      pwm_phase       <= pwm_phase_next;
      frame_ticks     <= frame_ticks_next;
      frame_index     <= frame_index_next;
      frame_byte      <= frame_byte_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/lcp_out_buf.sv
`default_nettype none
module lcp_out_buf import lcp_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         has_room,
  output logic         result_valid,
  input  wire logic    result_ready,
  output result_t      result
);

  logic    skid_valid;
  result_t skid;

  // a skid entry lets one more transfer in while the output stalls
  assign has_room = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || result_ready) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (!result_valid || result_ready) begin
      if (skid_valid)
        result <= skid;
      else if (push)
        result <= push_data;
    end else if (push) begin
      skid <= push_data;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/led_chaser_pwm_controller.sv
`default_nettype none
// Channel   Direction  Handshake                   Payload
// item      in         item_valid / item_ready     item_t: key, adc_valid, adc_value
// result    out        result_valid / result_ready result_t: led_drive .. running_now
//
// One tick per clock while item_ready is high: a transfer on item updates the
// state and its result is registered in the output buffer before it reaches result.
// The state update is a single combinational pass from the state registers to
// the output register; a two-entry output buffer keeps item_ready high while
// result stalls with an entry free, and it drops only when both entries are full.
// Synchronous reset: show mode, no pattern, 400-tick interval, running, LEDs off.
module led_chaser_pwm_controller import lcp_pkg::*; #(
  parameter int PWM_PERIOD = 100
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_ready,
  input  wire item_t   item,
  output logic         result_valid,
  input  wire logic    result_ready,
  output result_t      result
);

  logic    step;
  result_t core_result;

  assign step = item_valid & item_ready;

  lcp_core #(.PWM_PERIOD(PWM_PERIOD)) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .result (core_result)
  );

  lcp_out_buf u_out (
    .clk          (clk),
    .rst          (rst),
    .push         (step),
    .push_data    (core_result),
    .has_room     (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
`default_nettype wire
